// ----- src/edfrq_pkg.sv -----
`timescale 1ns / 1ps
// Package for the EDF ready queue: operation and status codes, sequencer
// states and the packed cell entry. No dependencies.
package edfrq_pkg;

    localparam int unsigned TASK_W = 6;
    localparam int unsigned TIME_W = 64;

    typedef enum logic [1:0] {
        MODE_SET   = 2'd0,
        MODE_ENQ   = 2'd1,
        MODE_DEQ   = 2'd2,
        MODE_CHECK = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_QUEUED = 2'd1,
        STAT_FULL   = 2'd2,
        STAT_ABSENT = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SET,
        S_ENQ_CHK,
        S_ENQ_ADD,
        S_INS_RD,
        S_INS_CMP,
        S_DEQ_CHK,
        S_DEQ_RD,
        S_DEQ_CMP,
        S_HEAD_RD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [TIME_W-1:0] deadline;
        logic [TASK_W-1:0] task_id;
    } t_cell;

endpackage

// ----- src/edf_ready_queue.sv -----
`timescale 1ns / 1ps
// EDF ready queue top level: sorted cell memory walked by a small sequencer.
// Depends on edfrq_pkg.
//
// channel  dir  handshake            payload
// s        in   i_s_tvalid/o_s_tready  tuser: mode; tdata: task, running, now, rel
// m        out  o_m_tvalid/i_m_tready  tdata: task, valid, resched, status
//
// A new beat is taken only while the sequencer is idle.
// Each cell step reads a cell in one state and writes it in the state after.
// Reset (i_rst_n low, synchronous) empties the queue and marks all relative
// deadlines unset at once, so they count as zero. A stalled result is held in
// the output register while the next beat may already be taken.
module edf_ready_queue
    import edfrq_pkg::*;
#(
    parameter int MAX_TASKS = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // [5:0] task_id, [6] running_valid, [70:7] now_time,
    // [134:71] relative_deadline, [135] zero
    input  logic [135:0] i_s_tdata,
    // [1:0] mode
    input  logic [1:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // [5:0] earliest_task, [6] earliest_valid, [7] resched, [9:8] status,
    // [15:10] zero
    output logic [15:0]  o_m_tdata
);

    localparam int CD = (MAX_TASKS < 64) ? MAX_TASKS : 64;
    localparam int AW = $clog2(CD);
    localparam int CW = $clog2(CD + 1);

    t_state               r_state, n_state;
    t_mode                r_mode;
    t_status              r_status, n_status;
    logic [TASK_W-1:0]    r_id;
    logic                 r_run;
    logic [TIME_W-1:0]    r_now, r_rel, r_abs, n_abs;
    logic [CW-1:0]        r_count, n_count, r_idx, n_idx;
    logic                 r_found, n_found;
    logic [CD-1:0]        r_mark, n_mark, r_rel_vld, n_rel_vld;
    logic                 r_out_vld, n_out_vld;
    logic [15:0]          r_out_data, n_out_data;

    t_cell                r_cells [CD];
    t_cell                r_rd;
    logic [TIME_W-1:0]    r_rel_mem [CD];
    logic [TIME_W-1:0]    r_rel_rd;

    logic                 w_cell_we, w_cell_re, w_rel_we, w_rel_re;
    logic [AW-1:0]        w_cell_wa, w_cell_ra;
    t_cell                w_cell_wd;
    logic                 w_accept, w_id_ok, w_head_vld, w_resched;
    logic [AW-1:0]        w_id_ix;
    logic [TASK_W-1:0]    w_head_task;

    assign w_accept   = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;
    assign w_id_ok    = (32'(r_id) < CD);
    assign w_id_ix    = r_id[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_cell_we) begin
            r_cells[w_cell_wa] <= w_cell_wd;
        end
        if (w_cell_re) begin
            r_rd <= r_cells[w_cell_ra];
        end
        if (w_rel_we) begin
            r_rel_mem[w_id_ix] <= r_rel;
        end
        if (w_rel_re) begin
            r_rel_rd <= r_rel_mem[w_id_ix];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_mark    <= '0;
            r_rel_vld <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_mark    <= n_mark;
            r_rel_vld <= n_rel_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= t_mode'(i_s_tuser);
            r_id   <= i_s_tdata[5:0];
            r_run  <= i_s_tdata[6];
            r_now  <= i_s_tdata[70:7];
            r_rel  <= i_s_tdata[134:71];
        end
        r_status   <= n_status;
        r_abs      <= n_abs;
        r_idx      <= n_idx;
        r_found    <= n_found;
        r_out_data <= n_out_data;
    end

    assign w_head_vld  = (r_count != '0);
    assign w_head_task = w_head_vld ? r_rd.task_id : '0;
    assign w_resched   = (r_mode == MODE_CHECK) && w_head_vld
                         && (!r_run || (w_head_task != r_id));

    always_comb begin
        n_state    = r_state;
        n_status   = r_status;
        n_abs      = r_abs;
        n_idx      = r_idx;
        n_found    = r_found;
        n_count    = r_count;
        n_mark     = r_mark;
        n_rel_vld  = r_rel_vld;
        n_out_vld  = r_out_vld && !i_m_tready;
        n_out_data = r_out_data;
        w_cell_we  = 1'b0;
        w_cell_re  = 1'b0;
        w_cell_wa  = '0;
        w_cell_ra  = '0;
        w_cell_wd  = '{deadline: r_abs, task_id: r_id};
        w_rel_we   = 1'b0;
        w_rel_re   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                n_status = STAT_OK;
                if (w_accept) begin
                    unique case (t_mode'(i_s_tuser))
                        MODE_SET:   n_state = S_SET;
                        MODE_ENQ:   n_state = S_ENQ_CHK;
                        MODE_DEQ:   n_state = S_DEQ_CHK;
                        MODE_CHECK: n_state = S_HEAD_RD;
                        default:    n_state = S_HEAD_RD;
                    endcase
                end
            end
            S_SET: begin
                if (w_id_ok) begin
                    w_rel_we           = 1'b1;
                    n_rel_vld[w_id_ix] = 1'b1;
                end
                n_state = S_HEAD_RD;
            end
            S_ENQ_CHK: begin
                if (!w_id_ok) begin
                    n_status = STAT_FULL;
                    n_state  = S_HEAD_RD;
                end else if (r_mark[w_id_ix]) begin
                    n_status = STAT_QUEUED;
                    n_state  = S_HEAD_RD;
                end else if (r_count >= CW'(CD)) begin
                    n_status = STAT_FULL;
                    n_state  = S_HEAD_RD;
                end else begin
                    w_rel_re = 1'b1;
                    n_state  = S_ENQ_ADD;
                end
            end
            S_ENQ_ADD: begin
                n_abs           = r_now + (r_rel_vld[w_id_ix] ? r_rel_rd : '0);
                n_idx           = r_count;
                n_mark[w_id_ix] = 1'b1;
                n_state         = S_INS_RD;
            end
            S_INS_RD: begin
                if (r_idx == '0) begin
                    w_cell_we = 1'b1;
                    w_cell_wa = '0;
                    n_count   = r_count + CW'(1);
                    n_state   = S_HEAD_RD;
                end else begin
                    w_cell_re = 1'b1;
                    w_cell_ra = AW'(r_idx - CW'(1));
                    n_state   = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                w_cell_we = 1'b1;
                w_cell_wa = AW'(r_idx);
                if (r_rd.deadline > r_abs) begin
                    w_cell_wd = r_rd;
                    n_idx     = r_idx - CW'(1);
                    n_state   = S_INS_RD;
                end else begin
                    n_count = r_count + CW'(1);
                    n_state = S_HEAD_RD;
                end
            end
            S_DEQ_CHK: begin
                if (!w_id_ok || !r_mark[w_id_ix]) begin
                    n_status = STAT_ABSENT;
                    n_state  = S_HEAD_RD;
                end else begin
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_state = S_DEQ_RD;
                end
            end
            S_DEQ_RD: begin
                w_cell_re = 1'b1;
                w_cell_ra = AW'(r_idx);
                n_state   = S_DEQ_CMP;
            end
            S_DEQ_CMP: begin
                if (r_found) begin
                    w_cell_we = 1'b1;
                    w_cell_wa = AW'(r_idx - CW'(1));
                    w_cell_wd = r_rd;
                end
                if (r_rd.task_id == r_id) begin
                    n_found = 1'b1;
                end
                n_idx = r_idx + CW'(1);
                if (r_idx == r_count - CW'(1)) begin
                    n_count         = r_count - CW'(1);
                    n_mark[w_id_ix] = 1'b0;
                    n_state         = S_HEAD_RD;
                end else begin
                    n_state = S_DEQ_RD;
                end
            end
            S_HEAD_RD: begin
                w_cell_re = 1'b1;
                w_cell_ra = '0;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_out_vld || i_m_tready) begin
                    n_out_vld  = 1'b1;
                    n_out_data = {6'd0, r_status, w_resched, w_head_vld, w_head_task};
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CD))
        else $error("queue count beyond capacity");

    a_mark_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ($countones(r_mark) == 32'(r_count)))
        else $error("queued marks disagree with queue count");

    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_s_tready)
        else $error("input taken while an operation is running");

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_cell_we)
        else $error("cell write while idle");

endmodule

// ----- tb/tb_edf_ready_queue.sv -----
`timescale 1ns / 1ps
// Self-checking bench for edf_ready_queue: sends random and directed beats and
// tracks the ready list in a scoreboard. Depends on edfrq_pkg and the block.
module tb_edf_ready_queue
    import edfrq_pkg::*;
;

    localparam int TASK_SLOTS  = 64;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_BEATS = 1000;

    typedef struct packed {
        logic [5:0] task_id;
        logic       valid;
        logic       resched;
        t_status    status;
    } t_head_result;

    class edf_scoreboard;
        logic [63:0]  rel_store [TASK_SLOTS];
        bit           queued [TASK_SLOTS];
        t_cell        ready_list [$];
        t_head_result pending_results [$];
        int           errors;

        function new();
            foreach (rel_store[i]) rel_store[i] = '0;
            foreach (queued[i]) queued[i] = 1'b0;
            errors = 0;
        endfunction

        function void note_beat(t_mode mode, logic [5:0] id, logic running,
                                logic [63:0] now, logic [63:0] rel);
            t_status      st;
            t_cell        entry;
            t_head_result r;
            int           pos;
            st  = STAT_OK;
            pos = 0;
            case (mode)
                MODE_SET: rel_store[id] = rel;
                MODE_ENQ: begin
                    if (queued[id]) begin
                        st = STAT_QUEUED;
                    end else if (ready_list.size() >= TASK_SLOTS) begin
                        st = STAT_FULL;
                    end else begin
                        entry.deadline = now + rel_store[id];
                        entry.task_id  = id;
                        while (pos < ready_list.size() &&
                               ready_list[pos].deadline <= entry.deadline)
                            pos++;
                        ready_list.insert(pos, entry);
                        queued[id] = 1'b1;
                    end
                end
                MODE_DEQ: begin
                    if (!queued[id]) begin
                        st = STAT_ABSENT;
                    end else begin
                        while (pos < ready_list.size() && ready_list[pos].task_id != id)
                            pos++;
                        if (pos < ready_list.size())
                            ready_list.delete(pos);
                        else
                            st = STAT_ABSENT;
                        queued[id] = 1'b0;
                    end
                end
                default: ;
            endcase
            r.valid   = ready_list.size() != 0;
            r.task_id = '0;
            if (r.valid)
                r.task_id = ready_list[0].task_id;
            r.resched = (mode == MODE_CHECK) && r.valid && (!running || r.task_id != id);
            r.status  = st;
            pending_results.push_back(r);
        endfunction

        function void check_beat(logic [15:0] d);
            t_head_result want;
            if (pending_results.size() == 0) begin
                $error("result beat %h with no prediction waiting", d);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (d[5:0] !== want.task_id) begin
                $error("earliest_task: expected %0d, got %0d", want.task_id, d[5:0]);
                errors++;
            end
            if (d[6] !== want.valid) begin
                $error("earliest_valid: expected %0d, got %0d", want.valid, d[6]);
                errors++;
            end
            if (d[7] !== want.resched) begin
                $error("resched: expected %0d, got %0d", want.resched, d[7]);
                errors++;
            end
            if (d[9:8] !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, d[9:8]);
                errors++;
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    // [5:0] task_id, [6] running_valid, [70:7] now_time,
    // [134:71] relative_deadline, [135] zero
    logic [135:0] i_s_tdata = '0;
    // [1:0] mode
    logic [1:0]   i_s_tuser = MODE_SET;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    // [5:0] earliest_task, [6] earliest_valid, [7] resched, [9:8] status,
    // [15:10] zero
    logic [15:0]  o_m_tdata;

    edf_scoreboard sb = new();
    int  cycle_count = 0;
    int  beats_sent = 0;
    bit  idle_on = 1'b1;
    bit  hold_req = 1'b0;
    bit  hold_done = 1'b0;

    edf_ready_queue #(.MAX_TASKS(TASK_SLOTS)) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_beat(o_m_tdata);
    end

    // Receiver: ready runs, random stall bursts, one long hold on request.
    initial begin
        i_m_tready = 1'b1;
        forever begin
            if (hold_req) begin
                i_m_tready = 1'b0;
                repeat (400) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 2) == 0) begin
                i_m_tready = 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge i_clk);
            end else begin
                i_m_tready = 1'b1;
                repeat ($urandom_range(1, 16)) @(negedge i_clk);
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Bias toward tiny and near-max values so deadlines tie and wrap.
    function automatic logic [63:0] pick_time();
        case ($urandom_range(0, 3))
            0: return 64'($urandom_range(0, 3));
            1: return ~64'($urandom_range(0, 3));
            default: return rand64();
        endcase
    endfunction

    // Call at a falling edge; returns at a falling edge after acceptance, at times after an idle gap with valid low.
    task automatic send_beat(t_mode mode, logic [5:0] id, logic running,
                             logic [63:0] now, logic [63:0] rel);
        i_s_tvalid = 1'b1;
        i_s_tuser  = mode;
        i_s_tdata  = {1'b0, rel, now, running, id};
        do
            @(posedge i_clk);
        while (!o_s_tready);
        sb.note_beat(mode, id, running, now, rel);
        beats_sent++;
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_s_tvalid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
    endtask

    task automatic shuffle_ids(ref int ids[TASK_SLOTS]);
        int j;
        int t;
        foreach (ids[i]) ids[i] = i;
        for (int i = TASK_SLOTS - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = ids[i];
            ids[i] = ids[j];
            ids[j] = t;
        end
    endtask

    // Fill every slot, poke the full list, then drain it in random order.
    task automatic fill_and_drain();
        int ids[TASK_SLOTS];
        shuffle_ids(ids);
        for (int i = 0; i < 16; i++)
            send_beat(MODE_SET, 6'(ids[i]), 1'($urandom), rand64(), pick_time());
        shuffle_ids(ids);
        foreach (ids[i])
            send_beat(MODE_ENQ, 6'(ids[i]), 1'($urandom), pick_time(), rand64());
        send_beat(MODE_ENQ, 6'($urandom), 1'($urandom), rand64(), rand64());
        for (int i = 0; i < 4; i++)
            send_beat(MODE_CHECK, 6'($urandom), 1'($urandom), rand64(), rand64());
        shuffle_ids(ids);
        foreach (ids[i])
            send_beat(MODE_DEQ, 6'(ids[i]), 1'($urandom), rand64(), rand64());
    endtask

    task automatic mixed_burst();
        logic [5:0] id;
        int         pick;
        for (int n = 0; n < 30; n++) begin
            id   = 6'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
                send_beat(MODE_SET, id, 1'($urandom), rand64(), pick_time());
            end else if (pick < 55) begin
                send_beat(MODE_ENQ, id, 1'($urandom), pick_time(), rand64());
            end else if (pick < 85) begin
                if (sb.ready_list.size() != 0 && $urandom_range(0, 3) != 0)
                    id = sb.ready_list[$urandom_range(0, sb.ready_list.size() - 1)].task_id;
                send_beat(MODE_DEQ, id, 1'($urandom), rand64(), rand64());
            end else begin
                if (sb.ready_list.size() != 0 && $urandom_range(0, 1) != 0)
                    id = sb.ready_list[0].task_id;
                send_beat(MODE_CHECK, id, 1'($urandom), rand64(), rand64());
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_beat(MODE_CHECK, 6'd0,  1'b1, '0, '0);
        send_beat(MODE_DEQ,   6'd5,  1'b0, '0, '0);
        send_beat(MODE_SET,   6'd0,  1'b0, '0, '1);
        send_beat(MODE_SET,   6'd63, 1'b1, '1, '0);
        send_beat(MODE_SET,   6'd1,  1'b0, '0, 64'd10);
        send_beat(MODE_ENQ,   6'd0,  1'b0, 64'd1, '0);
        send_beat(MODE_ENQ,   6'd63, 1'b1, '1, '1);
        send_beat(MODE_ENQ,   6'd1,  1'b0, '0, '0);
        send_beat(MODE_ENQ,   6'd2,  1'b0, 64'd10, '0);
        send_beat(MODE_ENQ,   6'd0,  1'b0, '0, '0);
        send_beat(MODE_SET,   6'd0,  1'b0, '0, 64'd5);
        send_beat(MODE_CHECK, 6'd0,  1'b1, '0, '0);
        send_beat(MODE_CHECK, 6'd1,  1'b1, '0, '0);
        send_beat(MODE_CHECK, 6'd0,  1'b0, '0, '0);
        send_beat(MODE_DEQ,   6'd0,  1'b0, '0, '0);
        send_beat(MODE_DEQ,   6'd0,  1'b0, '0, '0);
        send_beat(MODE_ENQ,   6'd0,  1'b0, '0, '0);
        send_beat(MODE_DEQ,   6'd63, 1'b0, '0, '0);
        send_beat(MODE_DEQ,   6'd2,  1'b0, '0, '0);
        send_beat(MODE_DEQ,   6'd1,  1'b0, '0, '0);
        send_beat(MODE_DEQ,   6'd0,  1'b0, '0, '0);
        send_beat(MODE_CHECK, 6'd9,  1'b0, '0, '0);

        beats_sent = 0;
        fill_and_drain();
        while (beats_sent < RANDOM_BEATS) begin
            if (!hold_done && beats_sent > 300) begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if (beats_sent > RANDOM_BEATS * 85 / 100)
                idle_on = 1'b0;
            if ($urandom_range(0, 7) == 0)
                fill_and_drain();
            else
                mixed_burst();
        end
        i_s_tvalid = 1'b0;

        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- edf_ready_queue.f -----
src/edfrq_pkg.sv
src/edf_ready_queue.sv
tb/tb_edf_ready_queue.sv
